FILE: rtl/hpt_pkg.sv
package hpt_pkg;

  localparam int NUM_GROUPS  = 1024;
  localparam int WAYS        = 8;
  localparam int GROUP_W     = $clog2(NUM_GROUPS);
  localparam int WAY_W       = $clog2(WAYS);
  localparam int TABLE_DEPTH = NUM_GROUPS * WAYS;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 32;
  localparam int SEG_W       = 24;
  localparam int MODE_W      = 7;
  localparam int VALID_POS   = WORD_W - 1;

  localparam logic [SEG_W-1:0] SEG_RESET = 24'h000400;
  localparam logic [SEG_W-1:0] HASH_MASK = SEG_W'(NUM_GROUPS - 1);

  typedef logic [9:0] group_idx_t;
  typedef logic [2:0] slot_idx_t;

  typedef enum logic [1:0] {
    OUT_MATCH = 2'd0,
    OUT_FREE  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0]       effective_address;
    logic [31:0]       physical_address;
    logic [MODE_W-1:0] mode_bits;
  } fill_t;

  typedef struct packed {
    group_idx_t  group_index;
    slot_idx_t   slot_index;
    logic [1:0]  outcome;
    logic [31:0] tag_word;
    logic [31:0] data_word;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free;
    logic [WAY_W-1:0] free_way;
  } scan_res_t;

endpackage

FILE: rtl/hashed_page_table_fill.sv
// Hashed page table fill. Each fill beat names a faulting effective address, a physical
// address and mode bits; the block hashes the segment id (ea[31:28] + segment_base) with
// ea[27:12] to a group of WAYS entries, reuses the first entry whose tag matches, else the
// first invalid entry, else the round-robin victim, writes the new tag, and returns one
// result beat. One fill at a time: the single read port of the tag RAM is read one way per
// cycle during the scan and then written once. After reset a clearing pass zeroes all
// NUM_GROUPS * WAYS (8192) tag RAM entries, one entry per cycle, with fill_ready low;
// segment_base writes are taken throughout. A finished result waits in an output register
// while the next fill proceeds.
module hashed_page_table_fill (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [hpt_pkg::SEG_W-1:0]    cfg_wr_data,
  input  logic                         fill_valid,
  output logic                         fill_ready,
  input  hpt_pkg::fill_t               fill,
  output logic                         result_valid,
  input  logic                         result_ready,
  output hpt_pkg::result_t             result
);

  hpt_pkg::state_t state, state_next;

  logic [hpt_pkg::SEG_W-1:0]   seg_base;
  logic [hpt_pkg::ADDR_W-1:0]  clr_addr;
  logic [hpt_pkg::WAY_W-1:0]   way;
  logic                        pend_valid;
  logic [hpt_pkg::WAY_W-1:0]   pend_way;
  logic [hpt_pkg::WORD_W-1:0]  tag;
  logic [hpt_pkg::WORD_W-1:0]  data;
  logic [hpt_pkg::GROUP_W-1:0] group;
  logic [hpt_pkg::WAY_W-1:0]   vp;

  logic [hpt_pkg::SEG_W-1:0]   seg_next;
  logic [hpt_pkg::SEG_W-1:0]   hash;
  logic [hpt_pkg::ADDR_W-1:0]  base;
  logic [hpt_pkg::WAY_W-1:0]   slot;
  hpt_pkg::outcome_t           outcome;
  hpt_pkg::scan_res_t          scan;

  logic                        ram_we;
  logic [hpt_pkg::ADDR_W-1:0]  ram_waddr;
  logic [hpt_pkg::WORD_W-1:0]  ram_wdata;
  logic [hpt_pkg::ADDR_W-1:0]  ram_raddr;
  logic [hpt_pkg::WORD_W-1:0]  ram_rdata;
  logic                        start;
  logic                        issue;
  logic                        done;

  assign seg_next = hpt_pkg::SEG_W'(fill.effective_address[31:28]) + seg_base;
  assign hash     = (seg_next ^ hpt_pkg::SEG_W'(fill.effective_address[27:12]))
                    & hpt_pkg::HASH_MASK;
  assign base     = hpt_pkg::ADDR_W'(group) * hpt_pkg::ADDR_W'(hpt_pkg::WAYS);

  always_comb begin
    priority if (scan.hit) begin
      slot    = scan.hit_way;
      outcome = hpt_pkg::OUT_MATCH;
    end else if (scan.free) begin
      slot    = scan.free_way;
      outcome = hpt_pkg::OUT_FREE;
    end else begin
      slot    = vp;
      outcome = hpt_pkg::OUT_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fill_ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    ram_raddr  = base + hpt_pkg::ADDR_W'(way);
    start      = 1'b0;
    issue      = 1'b0;
    done       = 1'b0;
    unique case (state)
      hpt_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == hpt_pkg::ADDR_W'(hpt_pkg::TABLE_DEPTH - 1)) begin
          state_next = hpt_pkg::ST_IDLE;
        end
      end
      hpt_pkg::ST_IDLE: begin
        fill_ready = 1'b1;
        if (fill_valid) begin
          start      = 1'b1;
          state_next = hpt_pkg::ST_SCAN;
        end
      end
      hpt_pkg::ST_SCAN: begin
        issue = 1'b1;
        if (way == hpt_pkg::WAY_W'(hpt_pkg::WAYS - 1)) begin
          state_next = hpt_pkg::ST_LAST;
        end
      end
      hpt_pkg::ST_LAST: begin
        state_next = hpt_pkg::ST_DONE;
      end
      hpt_pkg::ST_DONE: begin
        if (!result_valid || result_ready) begin
          done       = 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = base + hpt_pkg::ADDR_W'(slot);
          ram_wdata  = tag;
          state_next = hpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hpt_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_base     <= hpt_pkg::SEG_RESET;
      clr_addr     <= '0;
      way          <= '0;
      pend_valid   <= 1'b0;
      vp           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seg_base <= cfg_wr_data;
      end
      if (state == hpt_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (start) begin
        way <= '0;
      end else if (issue) begin
        way <= way + 1'b1;
      end
      pend_valid <= issue;
      if (done && outcome == hpt_pkg::OUT_EVICT) begin
        vp <= (vp == hpt_pkg::WAY_W'(hpt_pkg::WAYS - 1)) ? '0 : vp + 1'b1;
      end
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_way <= way;
    if (start) begin
      tag   <= {1'b1, seg_next, 1'b0, fill.effective_address[27:22]};
      data  <= {fill.physical_address[31:12], 5'b0, fill.mode_bits};
      group <= hpt_pkg::GROUP_W'(hash);
    end
    if (done) begin
      result.group_index <= hpt_pkg::group_idx_t'(group);
      result.slot_index  <= hpt_pkg::slot_idx_t'(slot);
      result.outcome     <= outcome;
      result.tag_word    <= tag;
      result.data_word   <= data;
    end
  end

  hpt_ram #(
    .WIDTH (hpt_pkg::WORD_W),
    .DEPTH (hpt_pkg::TABLE_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hpt_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .valid   (pend_valid),
    .way     (pend_way),
    .rd_data (ram_rdata),
    .tag     (tag),
    .res     (scan)
  );

endmodule

FILE: rtl/hpt_ram.sv
module hpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hpt_scan.sv
module hpt_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             valid,
  input  logic [hpt_pkg::WAY_W-1:0]        way,
  input  logic [hpt_pkg::WORD_W-1:0]       rd_data,
  input  logic [hpt_pkg::WORD_W-1:0]       tag,
  output hpt_pkg::scan_res_t               res
);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.hit  <= 1'b0;
      res.free <= 1'b0;
    end else if (valid) begin
      if (!res.hit && rd_data == tag) begin
        res.hit     <= 1'b1;
        res.hit_way <= way;
      end
      if (!res.free && !rd_data[hpt_pkg::VALID_POS]) begin
        res.free     <= 1'b1;
        res.free_way <= way;
      end
    end
  end

endmodule

FILE: rtl/hpt_checker.sv
module hpt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_wr_en,
  input logic [hpt_pkg::SEG_W-1:0] cfg_wr_data,
  input logic                      fill_valid,
  input logic                      fill_ready,
  input hpt_pkg::fill_t            fill,
  input logic                      result_valid,
  input logic                      result_ready,
  input hpt_pkg::result_t          result
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !fill_ready && !result_valid)
    else $error("ready or result valid right after reset");

  a_one_fill: assert property (@(posedge clk) disable iff (rst)
    fill_valid && fill_ready |=> !fill_ready)
    else $error("second fill taken while one is in progress");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_result_form: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.tag_word[hpt_pkg::VALID_POS] && !result.tag_word[6]
                     && result.data_word[11:7] == 5'b0)
    else $error("malformed entry words");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.outcome == hpt_pkg::OUT_MATCH
                     || result.outcome == hpt_pkg::OUT_FREE
                     || result.outcome == hpt_pkg::OUT_EVICT)
    else $error("undefined outcome code");

endmodule

bind hashed_page_table_fill hpt_checker u_hpt_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hpt_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_wr_en = 1'b0;
  logic [SEG_W-1:0] cfg_wr_data = '0;
  logic     fill_valid = 1'b0;
  logic     fill_ready;
  fill_t    fill = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  result_t  result;

  hashed_page_table_fill dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fill_valid   (fill_valid),
    .fill_ready   (fill_ready),
    .fill         (fill),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fill_t            pending_fills[$];
  result_t          expected_results[$];
  logic [WORD_W-1:0] tag_shadow [TABLE_DEPTH];
  int               victim_ptr = 0;
  logic [SEG_W-1:0] seg_base = SEG_RESET;
  int               errors = 0;
  logic             quiet = 1'b0;
  logic             hold_req = 1'b0;
  logic             fill_beat = 1'b0;
  int               send_gap = 0;
  int               stall_left = 0;
  int               hold_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic result_t predict_fill(fill_t f);
    logic [SEG_W-1:0]   seg;
    logic [WORD_W-1:0]  tag;
    logic [GROUP_W-1:0] grp;
    int                 base;
    int                 slot;
    logic               found;
    outcome_t           how;
    result_t            r;
    seg = SEG_W'(f.effective_address[31:28]) + seg_base;
    tag = {1'b1, seg, 1'b0, f.effective_address[27:22]};
    grp = seg[GROUP_W-1:0] ^ f.effective_address[12 +: GROUP_W];
    base = int'(grp) * WAYS;
    found = 1'b0;
    slot = 0;
    how = OUT_MATCH;
    for (int w = 0; w < WAYS && !found; w++) begin
      if (tag_shadow[base + w] == tag) begin
        slot = w;
        found = 1'b1;
      end
    end
    if (!found) begin
      how = OUT_FREE;
      for (int w = 0; w < WAYS && !found; w++) begin
        if (!tag_shadow[base + w][VALID_POS]) begin
          slot = w;
          found = 1'b1;
        end
      end
    end
    if (!found) begin
      how = OUT_EVICT;
      slot = victim_ptr % WAYS;
      victim_ptr = (slot + 1) % WAYS;
    end
    tag_shadow[base + slot] = tag;
    r.group_index = grp;
    r.slot_index = slot[WAY_W-1:0];
    r.outcome = how;
    r.tag_word = tag;
    r.data_word = {f.physical_address[31:12], 5'b0, f.mode_bits};
    return r;
  endfunction

  function automatic logic [31:0] aim_ea(int grp, logic [3:0] nib, logic [5:0] page,
                                         logic [11:0] low);
    logic [SEG_W-1:0]   seg;
    logic [GROUP_W-1:0] hash_lo;
    seg = SEG_W'(nib) + seg_base;
    hash_lo = grp[GROUP_W-1:0] ^ seg[GROUP_W-1:0];
    return {nib, page, hash_lo, low};
  endfunction

  task automatic push_fill(logic [31:0] ea, logic [31:0] pa, logic [MODE_W-1:0] mode);
    fill_t f;
    f.effective_address = ea;
    f.physical_address = pa;
    f.mode_bits = mode;
    pending_fills.push_back(f);
  endtask

  task automatic write_base(logic [SEG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    seg_base = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // advance to the next fill once the current beat is taken
  always @(negedge clk) begin
    if (rst) begin
      fill_valid <= 1'b0;
    end else if (!fill_valid || fill_beat) begin
      if (send_gap > 0) begin
        fill_valid <= 1'b0;
        send_gap--;
      end else if (pending_fills.size() > 0) begin
        fill <= pending_fills.pop_front();
        fill_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        fill_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (rst || hold_left > 0 || stall_left > 0) begin
      result_ready <= 1'b0;
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
    end else begin
      result_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    fill_beat <= !rst && fill_valid && fill_ready;
    if (!rst && fill_valid && fill_ready) expected_results.push_back(predict_fill(fill));
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("group_index", 32'(want.group_index), 32'(result.group_index));
        check_field("slot_index", 32'(want.slot_index), 32'(result.slot_index));
        check_field("outcome", 32'(want.outcome), 32'(result.outcome));
        check_field("tag_word", want.tag_word, result.tag_word);
        check_field("data_word", want.data_word, result.data_word);
      end
    end
  end

  initial begin
    logic [SEG_W-1:0] bases[6];
    int               hot[4];
    int               count;
    int               grp;
    logic [3:0]       nib;
    logic [5:0]       page;
    logic [31:0]      ea;
    for (int i = 0; i < TABLE_DEPTH; i++) tag_shadow[i] = '0;
    bases[0] = SEG_RESET;
    bases[1] = '0;
    bases[2] = 24'hFFFFF0;
    bases[3] = SEG_W'($urandom_range(0, 24'hFFFFF0));
    bases[4] = 24'hFFFFFF;
    bases[5] = SEG_W'($urandom_range(0, 24'hFFFFF0));
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      write_base(bases[phase]);
      quiet = (phase == 1);
      count = 175;
      if (phase == 0) begin
        push_fill(32'h0, 32'h0, 7'h00);
        push_fill(32'hFFFFFFFF, 32'hFFFFFFFF, 7'h7F);
        push_fill(32'h0, 32'hFFFFF123, 7'h55);
        for (int p = 0; p < 10; p++)
          push_fill(aim_ea(5, 4'h3, 6'(p), 12'hABC), $urandom(), MODE_W'(p));
        push_fill(aim_ea(5, 4'h3, 6'd2, 12'h000), 32'h12345FFF, 7'h2A);
        push_fill(aim_ea(5, 4'hF, 6'h3F, 12'hFFF), 32'h00000FFF, 7'h7F);
        push_fill(aim_ea(NUM_GROUPS - 1, 4'hF, 6'h3F, 12'h000), 32'hFFFFF000, 7'h00);
        push_fill(aim_ea(0, 4'h0, 6'h00, 12'hFFF), 32'h80000000, 7'h01);
        count = 158;
      end
      for (int k = 0; k < 4; k++) hot[k] = $urandom_range(0, NUM_GROUPS - 1);
      for (int n = 0; n < count; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          ea = $urandom();
        end else begin
          grp = hot[$urandom_range(0, 3)];
          nib = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 2));
          page = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 9));
          ea = aim_ea(grp, nib, page, 12'($urandom_range(0, 4095)));
        end
        push_fill(ea, $urandom(), MODE_W'($urandom_range(0, 127)));
      end
      if (phase == 2) hold_req = 1'b1;
      while (pending_fills.size() != 0 || fill_valid || expected_results.size() != 0)
        @(posedge clk);
      repeat (30) @(negedge clk);
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/hpt_pkg.sv
rtl/hpt_ram.sv
rtl/hpt_scan.sv
rtl/hashed_page_table_fill.sv
rtl/hpt_checker.sv
test/testbench.sv
